// ===== rtl/core/dmcu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the DoP marker check and unpack unit.
package dmcu_pkg;

  localparam int MAX_CHANNELS   = 6;
  localparam int SAMPLE_W       = 24;
  localparam int MARK_W         = 8;
  localparam int DSD_W          = 16;
  localparam int BIT_IDX_W      = 4;
  localparam int CH_COUNT_W     = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 3;

  localparam logic [MARK_W-1:0] MARK_A    = 8'h05;
  localparam logic [MARK_W-1:0] MARK_B    = 8'hFA;
  localparam logic [MARK_W-1:0] MARK_NONE = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ONLY    = 1'd1;

  localparam logic [CH_COUNT_W-1:0] CH_COUNT_RESET = 3'd2;

  // One checked frame waiting to be sent out.
  typedef struct packed {
    logic                               err;
    logic [MAX_CHANNELS-1:0][DSD_W-1:0] data;
  } frame_t;

endpackage

// ===== rtl/core/dmcu_lane.sv =====
`timescale 1ns / 1ps
// Per-channel lane: last marker register and alternation check.
module dmcu_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       active,
  input  logic [dmcu_pkg::MARK_W-1:0] mark,
  input  logic                       update,
  output logic                       ok
);

  logic [dmcu_pkg::MARK_W-1:0] marker;

  always_comb begin
    if (!active) begin
      ok = 1'b1;
    end else if (marker == dmcu_pkg::MARK_NONE) begin
      ok = (mark == dmcu_pkg::MARK_A) || (mark == dmcu_pkg::MARK_B);
    end else begin
      ok = (mark == ~marker);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= dmcu_pkg::MARK_NONE;
    end else if (update && active) begin
      marker <= mark;
    end
  end

endmodule

// ===== rtl/core/dmcu_merge.sv =====
`timescale 1ns / 1ps
// Combines lane verdicts, tracks the halted latch and builds the frame to send.
module dmcu_merge (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   accept,
  input  logic                                                   check_only,
  input  logic [dmcu_pkg::MAX_CHANNELS-1:0]                      active,
  input  logic [dmcu_pkg::MAX_CHANNELS-1:0]                      lane_ok,
  input  logic [dmcu_pkg::MAX_CHANNELS-1:0][dmcu_pkg::DSD_W-1:0] data,
  output logic                                                   update,
  output logic                                                   push,
  output dmcu_pkg::frame_t                                       frame
);

  logic halted;
  logic good;

  assign good   = !halted && (&lane_ok);
  assign update = accept && good;
  assign push   = accept && (!good || !check_only);

  always_comb begin
    frame.err = !good;
    for (int k = 0; k < dmcu_pkg::MAX_CHANNELS; k++) begin
      frame.data[k] = (active[k] && good) ? data[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
    end else if (accept && !good) begin
      halted <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/dmcu_serial.sv =====
`timescale 1ns / 1ps
// One-frame hold buffer and 16-beat bit serializer driving the result channel.
module dmcu_serial (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  dmcu_pkg::frame_t                     frame_in,
  output logic                                 hold_full,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dmcu_pkg::MAX_CHANNELS-1:0]    dsd_bits,
  output logic                                 last,
  output logic                                 marker_error
);

  logic                              hold_valid;
  dmcu_pkg::frame_t                  hold;
  logic                              busy;
  dmcu_pkg::frame_t                  cur;
  logic [dmcu_pkg::BIT_IDX_W-1:0]    cnt;
  logic [dmcu_pkg::BIT_IDX_W-1:0]    bitpos;
  logic                              beat;
  logic                              finish;
  logic                              load;

  assign bitpos    = ~cnt;
  assign out_valid = busy;
  assign last      = cur.err || (cnt == {dmcu_pkg::BIT_IDX_W{1'b1}});
  assign marker_error = cur.err;
  assign beat      = busy && out_ready;
  assign finish    = beat && last;
  assign load      = hold_valid && (!busy || finish);
  assign hold_full = hold_valid;

  always_comb begin
    for (int k = 0; k < dmcu_pkg::MAX_CHANNELS; k++) begin
      dsd_bits[k] = cur.data[k][bitpos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      busy       <= 1'b0;
      cnt        <= '0;
    end else begin
      if (push) begin
        hold_valid <= 1'b1;
      end else if (load) begin
        hold_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (beat) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hold <= frame_in;
    end
    if (load) begin
      cur <= hold;
    end
  end

endmodule

// ===== rtl/core/dop_marker_check_and_unpack_unit.sv =====
`timescale 1ns / 1ps
// Top level of the DoP marker check and unpack unit.
// Each input beat is one PCM frame of six 24-bit samples; channels at or above
// channel_count are ignored, a count of zero acting as one and a count above
// six as six. Markers are checked by one lane per channel at the moment the
// frame is accepted, so a following frame is checked against the updated
// markers with no bubble. A good frame gives 16 result beats (DSD bit 15
// first, one bit per channel); a bad marker or a halted block gives a single
// error beat; a good frame in check-only mode gives none. Results leave
// through a 16-beat serializer backed by a one-frame hold buffer, so the unit
// takes the next frame while the current one is still being sent; in_ready
// is low while the hold buffer is full. Only reset clears the halted state.
module dop_marker_check_and_unpack_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dmcu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmcu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch0,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch1,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch2,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch3,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch4,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch5,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dmcu_pkg::MAX_CHANNELS-1:0]   dsd_bits,
  output logic                                last,
  output logic                                marker_error
);

  logic [dmcu_pkg::CH_COUNT_W-1:0]                            channel_count;
  logic                                                       check_only;
  logic [dmcu_pkg::CH_COUNT_W-1:0]                            n_active;
  logic [dmcu_pkg::MAX_CHANNELS-1:0]                          active;
  logic [dmcu_pkg::MAX_CHANNELS-1:0][dmcu_pkg::SAMPLE_W-1:0]  samples;
  logic [dmcu_pkg::MAX_CHANNELS-1:0][dmcu_pkg::DSD_W-1:0]     data;
  logic [dmcu_pkg::MAX_CHANNELS-1:0]                          lane_ok;
  logic                                                       accept;
  logic                                                       update;
  logic                                                       push;
  logic                                                       hold_full;
  dmcu_pkg::frame_t                                           frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= dmcu_pkg::CH_COUNT_RESET;
      check_only    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dmcu_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data;
        dmcu_pkg::REG_CHECK_ONLY:    check_only    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (channel_count == '0) begin
      n_active = dmcu_pkg::CH_COUNT_W'(1);
    end else if (channel_count > dmcu_pkg::CH_COUNT_W'(dmcu_pkg::MAX_CHANNELS)) begin
      n_active = dmcu_pkg::CH_COUNT_W'(dmcu_pkg::MAX_CHANNELS);
    end else begin
      n_active = channel_count;
    end
    for (int k = 0; k < dmcu_pkg::MAX_CHANNELS; k++) begin
      active[k] = dmcu_pkg::CH_COUNT_W'(k) < n_active;
    end
  end

  assign samples = {sample_ch5, sample_ch4, sample_ch3, sample_ch2, sample_ch1, sample_ch0};

  assign in_ready = !hold_full;
  assign accept   = in_valid && in_ready;

  for (genvar k = 0; k < dmcu_pkg::MAX_CHANNELS; k++) begin : g_lane
    assign data[k] = samples[k][dmcu_pkg::DSD_W-1:0];
    dmcu_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .active (active[k]),
      .mark   (samples[k][dmcu_pkg::SAMPLE_W-1:dmcu_pkg::DSD_W]),
      .update (update),
      .ok     (lane_ok[k])
    );
  end

  dmcu_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .check_only (check_only),
    .active     (active),
    .lane_ok    (lane_ok),
    .data       (data),
    .update     (update),
    .push       (push),
    .frame      (frame)
  );

  dmcu_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .frame_in     (frame),
    .hold_full    (hold_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dsd_bits     (dsd_bits),
    .last         (last),
    .marker_error (marker_error)
  );

endmodule

// ===== dv/dmcu_checker.sv =====
`timescale 1ns / 1ps
// Checker for the DoP unpack unit: predicts the result beats of each frame and compares them.
module dmcu_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dmcu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmcu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch0,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch1,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch2,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch3,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch4,
  input  logic [dmcu_pkg::SAMPLE_W-1:0]       sample_ch5,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [dmcu_pkg::MAX_CHANNELS-1:0]   dsd_bits,
  input  logic                                last,
  input  logic                                marker_error,
  output int                                  fails,
  output int                                  pending,
  output int                                  beats_seen
);
  import dmcu_pkg::*;

  typedef struct packed {
    logic [MAX_CHANNELS-1:0] bits;
    logic                    last;
    logic                    err;
  } dsd_beat_t;

  dsd_beat_t             dsd_beat_q[$];
  dsd_beat_t             want;
  logic [MARK_W-1:0]     seen_mark [MAX_CHANNELS];
  logic                  halt_seen;
  logic [CH_COUNT_W-1:0] chan_cfg;
  logic                  check_cfg;

  // Marker check and bit unpacking for one accepted frame.
  task automatic unpack_frame(input logic [MAX_CHANNELS*SAMPLE_W-1:0] frame);
    int n;
    logic ok;
    logic [MARK_W-1:0] m;
    dsd_beat_t b;
    n = int'(chan_cfg);
    if (n == 0) n = 1;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    ok = !halt_seen;
    if (!halt_seen) begin
      for (int ch = 0; ch < n; ch++) begin
        m = frame[ch*SAMPLE_W + DSD_W +: MARK_W];
        if (seen_mark[ch] == MARK_NONE) begin
          if (m != MARK_A && m != MARK_B) ok = 1'b0;
        end else if (m != ~seen_mark[ch]) begin
          ok = 1'b0;
        end
      end
    end
    if (!ok) begin
      halt_seen = 1'b1;
      b.bits = '0;
      b.last = 1'b1;
      b.err = 1'b1;
      dsd_beat_q.push_back(b);
    end else begin
      for (int ch = 0; ch < n; ch++) seen_mark[ch] = frame[ch*SAMPLE_W + DSD_W +: MARK_W];
      if (!check_cfg) begin
        for (int j = DSD_W - 1; j >= 0; j--) begin
          b.bits = '0;
          for (int ch = 0; ch < n; ch++) b.bits[ch] = frame[ch*SAMPLE_W + j];
          b.last = (j == 0);
          b.err = 1'b0;
          dsd_beat_q.push_back(b);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dsd_beat_q.delete();
      for (int ch = 0; ch < MAX_CHANNELS; ch++) seen_mark[ch] = MARK_NONE;
      halt_seen = 1'b0;
      chan_cfg = CH_COUNT_RESET;
      check_cfg = 1'b0;
    end else begin
      if (in_valid && in_ready)
        unpack_frame({sample_ch5, sample_ch4, sample_ch3, sample_ch2, sample_ch1, sample_ch0});
      if (cfg_we) begin
        if (cfg_index == REG_CHANNEL_COUNT) chan_cfg = cfg_data[CH_COUNT_W-1:0];
        else if (cfg_index == REG_CHECK_ONLY) check_cfg = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        beats_seen++;
        if (dsd_beat_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none, got bits=%h last=%b err=%b",
                   $time, dsd_bits, last, marker_error);
        end else begin
          want = dsd_beat_q.pop_front();
          if (dsd_bits !== want.bits) begin
            fails++;
            $display("%0t: dsd_bits expected %h, got %h", $time, want.bits, dsd_bits);
          end
          if (last !== want.last) begin
            fails++;
            $display("%0t: last expected %b, got %b", $time, want.last, last);
          end
          if (marker_error !== want.err) begin
            fails++;
            $display("%0t: marker_error expected %b, got %b", $time, want.err, marker_error);
          end
        end
      end
    end
    pending = dsd_beat_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the DoP unpack testbench: clock, reset, frame stimulus, output stalls and verdict.
module testbench;
  import dmcu_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int LONG_HOLD     = 300;
  localparam int CLEAN_FRAMES  = 385;
  localparam int HALT_FRAMES   = 25;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     sample_ch0, sample_ch1, sample_ch2;
  logic [SAMPLE_W-1:0]     sample_ch3, sample_ch4, sample_ch5;
  logic                    out_valid;
  logic                    out_ready;
  logic [MAX_CHANNELS-1:0] dsd_bits;
  logic                    last;
  logic                    marker_error;

  int fails, pending, beats_seen;

  logic [MARK_W-1:0]     tx_mark [MAX_CHANNELS];
  logic [CH_COUNT_W-1:0] cur_count;
  int                    tx_gap_max;
  int                    rx_gap_max;
  bit                    long_hold_req;
  int                    frames_sent;
  int                    settings_used;
  int                    halt_frame;

  always #1 clk = ~clk;

  dop_marker_check_and_unpack_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_ch0(sample_ch0), .sample_ch1(sample_ch1), .sample_ch2(sample_ch2),
    .sample_ch3(sample_ch3), .sample_ch4(sample_ch4), .sample_ch5(sample_ch5),
    .out_valid(out_valid), .out_ready(out_ready),
    .dsd_bits(dsd_bits), .last(last), .marker_error(marker_error)
  );

  dmcu_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_ch0(sample_ch0), .sample_ch1(sample_ch1), .sample_ch2(sample_ch2),
    .sample_ch3(sample_ch3), .sample_ch4(sample_ch4), .sample_ch5(sample_ch5),
    .out_valid(out_valid), .out_ready(out_ready),
    .dsd_bits(dsd_bits), .last(last), .marker_error(marker_error),
    .fails(fails), .pending(pending), .beats_seen(beats_seen)
  );

  function automatic int active_count();
    if (cur_count == 0) return 1;
    if (cur_count > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(cur_count);
  endfunction

  task automatic send_frame(input logic [MAX_CHANNELS*SAMPLE_W-1:0] frame);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0 && in_valid) in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
    sample_ch0 <= frame[0*SAMPLE_W +: SAMPLE_W];
    sample_ch1 <= frame[1*SAMPLE_W +: SAMPLE_W];
    sample_ch2 <= frame[2*SAMPLE_W +: SAMPLE_W];
    sample_ch3 <= frame[3*SAMPLE_W +: SAMPLE_W];
    sample_ch4 <= frame[4*SAMPLE_W +: SAMPLE_W];
    sample_ch5 <= frame[5*SAMPLE_W +: SAMPLE_W];
    in_valid <= 1'b1;
    @(posedge clk iff in_ready);
    @(negedge clk);
    frames_sent++;
  endtask

  // Well-formed frame: every active channel flips its marker; first marker is
  // 0xFA on even channels and 0x05 on odd ones.
  task automatic send_dop_frame(input logic [DSD_W-1:0] even_data,
                                input logic [DSD_W-1:0] odd_data,
                                input bit rand_fill,
                                input logic [SAMPLE_W-1:0] idle_sample);
    logic [MAX_CHANNELS*SAMPLE_W-1:0] frame;
    logic [DSD_W-1:0] d;
    logic [SAMPLE_W-1:0] s;
    int n;
    n = active_count();
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      if (ch < n) begin
        if (tx_mark[ch] == MARK_NONE) tx_mark[ch] = (ch % 2 == 1) ? MARK_A : MARK_B;
        else tx_mark[ch] = ~tx_mark[ch];
        if (rand_fill) d = DSD_W'($urandom);
        else d = (ch % 2 == 1) ? odd_data : even_data;
        frame[ch*SAMPLE_W +: SAMPLE_W] = {tx_mark[ch], d};
      end else begin
        if (rand_fill) s = SAMPLE_W'($urandom);
        else s = idle_sample;
        frame[ch*SAMPLE_W +: SAMPLE_W] = s;
      end
    end
    send_frame(frame);
  endtask

  // Good frame except for one active channel with a wrong marker.
  task automatic send_bad_marker();
    logic [MAX_CHANNELS*SAMPLE_W-1:0] frame;
    logic [MARK_W-1:0] m;
    logic [DSD_W-1:0] d;
    int n, victim;
    n = active_count();
    victim = $urandom_range(0, n - 1);
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      d = DSD_W'($urandom);
      m = (tx_mark[ch] == MARK_NONE) ? MARK_B : ~tx_mark[ch];
      frame[ch*SAMPLE_W +: SAMPLE_W] = {m, d};
    end
    case ($urandom_range(0, 3))
      0: m = 8'hFF;
      1: m = MARK_NONE;
      2: m = (tx_mark[victim] == MARK_NONE) ? 8'hFF : tx_mark[victim];
      default: begin
        m = MARK_W'($urandom);
        if (m == MARK_A || m == MARK_B) m = 8'h7E;
      end
    endcase
    frame[victim*SAMPLE_W + DSD_W +: MARK_W] = m;
    send_frame(frame);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input logic [CH_COUNT_W-1:0] cnt, input logic chk_only);
    logic [CFG_DATA_W-1:0] d;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data <= cnt;
    @(negedge clk);
    d = CFG_DATA_W'($urandom);
    d[0] = chk_only;
    cfg_index <= REG_CHECK_ONLY;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_count = cnt;
    settings_used++;
  endtask

  // Output side: per-beat random stall, plus one long hold on request.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (long_hold_req && !held) begin
        held = 1'b1;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int len, mode;
    logic [MAX_CHANNELS*SAMPLE_W-1:0] junk;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_ch0 = '0; sample_ch1 = '0; sample_ch2 = '0;
    sample_ch3 = '0; sample_ch4 = '0; sample_ch5 = '0;
    for (int ch = 0; ch < MAX_CHANNELS; ch++) tx_mark[ch] = MARK_NONE;
    cur_count = CH_COUNT_RESET;
    tx_gap_max = 2;
    rx_gap_max = 2;
    long_hold_req = 1'b0;
    frames_sent = 0;
    settings_used = 0;
    halt_frame = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: two channels, data output on
    send_dop_frame(16'hFFFF, 16'h0000, 1'b0, 24'hFFFFFF);
    send_dop_frame(16'h0000, 16'hFFFF, 1'b0, 24'h000000);
    send_dop_frame(16'hAAAA, 16'h5555, 1'b0, {8'h33, 16'hC3C3});
    // all six, new channels see their first marker
    write_regs(3'd6, 1'b0);
    send_dop_frame(16'hFFFF, 16'hFFFF, 1'b0, '0);
    send_dop_frame(16'h0000, 16'h0000, 1'b0, '0);
    send_dop_frame(16'h8001, 16'h7FFE, 1'b0, '0);
    send_dop_frame('0, '0, 1'b1, '0);
    // zero count acts as one channel; others carry junk markers
    write_regs(3'd0, 1'b0);
    send_dop_frame(16'hFFFF, 16'h0000, 1'b0, {MARK_A, 16'hFFFF});
    send_dop_frame(16'h1234, 16'h0000, 1'b0, {8'hFF, 16'h0000});
    // count above six clamps to six
    write_regs(3'd7, 1'b0);
    send_dop_frame(16'h0F0F, 16'hF0F0, 1'b0, '0);
    send_dop_frame('0, '0, 1'b1, '0);
    // check-only: markers advance, no beats
    write_regs(3'd6, 1'b1);
    send_dop_frame(16'hFFFF, 16'hFFFF, 1'b0, '0);
    send_dop_frame('0, '0, 1'b1, '0);
    send_dop_frame('0, '0, 1'b1, '0);
    write_regs(3'd1, 1'b0);
    send_dop_frame(16'hFFFF, 16'hFFFF, 1'b0, 24'hFFFFFF);
    send_dop_frame('0, '0, 1'b1, '0);

    for (int ph = 0; frames_sent < CLEAN_FRAMES; ph++) begin
      mode = $urandom_range(0, 4);
      case (mode)
        0: begin tx_gap_max = 0;  rx_gap_max = 0;  end
        1: begin tx_gap_max = 14; rx_gap_max = 14; end
        2: begin tx_gap_max = 14; rx_gap_max = 0;  end
        3: begin tx_gap_max = 0;  rx_gap_max = 14; end
        default: begin tx_gap_max = 3; rx_gap_max = 3; end
      endcase
      write_regs(CH_COUNT_W'($urandom_range(0, 7)),
                 (ph != 1) && ($urandom_range(0, 3) == 0));
      if (ph == 1) begin
        tx_gap_max = 0;
        long_hold_req = 1'b1;
      end
      len = $urandom_range(20, 50);
      for (int k = 0; k < len; k++) begin
        if (k == len / 2 && (ph == 0 || $urandom_range(0, 2) == 0)) wait_drained();
        send_dop_frame('0, '0, 1'b1, '0);
      end
    end

    // one bad marker latches halt; everything after is an error beat
    tx_gap_max = 6;
    rx_gap_max = 6;
    write_regs(CH_COUNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    halt_frame = frames_sent + 1;
    send_bad_marker();
    for (int k = 0; k < HALT_FRAMES; k++) begin
      if (k == HALT_FRAMES / 2)
        write_regs(CH_COUNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 1) begin
        send_dop_frame('0, '0, 1'b1, '0);
      end else begin
        for (int ch = 0; ch < MAX_CHANNELS; ch++)
          junk[ch*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
        send_frame(junk);
      end
    end

    wait_drained();
    $display("Frames sent: %0d under %0d register settings; result beats checked: %0d.",
             frames_sent, settings_used, beats_seen);
    $display("Halt latched at frame %0d, then %0d frames sent while halted.",
             halt_frame, HALT_FRAMES);
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
